// File: hdl/nspm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspm_pkg
// Shared types and constants of the nearest screen pointer mapper.
// ----------------------------------------------------------------------------
package nspm_pkg;

   localparam int XW  = 28;          // signed Q.8 coordinate width
   localparam int DSW = 2 * XW + 1;  // squared distance sum width
   localparam int TW  = 23;          // clamped source offset width
   localparam int DW  = TW + 15;     // scale product and dividend width
   localparam int REQ_W = 176;
   localparam int RSP_W = 32;

   localparam logic [2:0] CSR_SCREEN_COUNT = 3'd0;
   localparam logic [2:0] CSR_BOX_ORIGIN_X = 3'd1;
   localparam logic [2:0] CSR_BOX_ORIGIN_Y = 3'd2;
   localparam logic [2:0] CSR_BOX_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_BOX_HEIGHT   = 3'd4;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_MAP  = 1'b1;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        width;
      logic [14:0]        height;
   } rect_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic square;
      logic compare;
      logic map_set;
      logic div_step;
      logic place;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

// File: hdl/nspm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspm_ctrl
// Sequencer: screen search walk, serial divide and result placement.
// ----------------------------------------------------------------------------
module nspm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_action,
   output logic             req_tready,
   input  nspm_pkg::sts_type sts,
   output nspm_pkg::cmd_type cmd
);
   import nspm_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_FETCH  = 7'b0000010,
      ST_SQUARE = 7'b0000100,
      ST_CMP    = 7'b0001000,
      ST_MAPSET = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_PLACE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && req_action == ACT_MAP) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (sts.more) begin
               cmd.fetch = 1'b1;
               state_in  = ST_SQUARE;
            end else begin
               state_in = ST_MAPSET;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_MAPSET: begin
            cmd.map_set = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_PLACE;
         end
         ST_PLACE: begin
            if (sts.out_free) begin
               cmd.place = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: hdl/nspm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nspm_dp
// Datapath: screen table, distance unit, two-lane serial divider, placement.
// ----------------------------------------------------------------------------
module nspm_dp #(
   parameter int MAX_SCREENS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [nspm_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        req_action,
   input  logic                        csr_valid,
   input  logic [2:0]                  csr_index,
   input  logic [15:0]                 csr_data,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [nspm_pkg::RSP_W-1:0]  rsp_tdata,
   input  nspm_pkg::cmd_type           cmd,
   output nspm_pkg::sts_type           sts
);
   import nspm_pkg::*;

   localparam int IW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
   localparam int CW = $clog2(MAX_SCREENS + 1);

   rect_type src_tab_ff [MAX_SCREENS];
   rect_type dst_tab_ff [MAX_SCREENS];

   logic [2:0]         count_ff;
   logic signed [15:0] org_x_ff, org_y_ff;
   logic [14:0]        box_w_ff, box_h_ff;

   logic signed [23:0] px_ff, py_ff;
   logic [CW-1:0]      idx_ff;
   logic [IW-1:0]      best_ff;
   logic               found_ff;
   logic [DSW-1:0]     best_d_ff;
   logic signed [XW-1:0] dx_ff, dy_ff;
   logic               skip_ff;
   logic [2*XW-1:0]    sqx_ff, sqy_ff;
   logic [DW-1:0]      numx_ff, numy_ff;
   logic [15:0]        remx_ff, remy_ff;
   logic [5:0]         dcnt_ff;
   logic               rsp_valid_ff;
   logic [14:0]        pos_x_ff, pos_y_ff;

   rect_type in_src, in_dst, cur_src, sel_src, sel_dst;
   logic [1:0]     in_slot;
   logic [CW-1:0]  lim;
   logic [DSW-1:0] dist_sum;
   logic [14:0]    pos_x_in, pos_y_in;

   function automatic logic signed [XW-1:0] axis_dx(logic signed [23:0] p,
         logic signed [15:0] org, logic [14:0] size);
      logic signed [XW-1:0] lo, hi, pe, c;
      lo = XW'(org) <<< 8;
      hi = (XW'(org) + $signed({{(XW-15){1'b0}}, size}) - XW'(1)) <<< 8;
      pe = XW'(p);
      c  = (pe < lo) ? lo : ((pe > hi) ? hi : pe);
      return c - pe;
   endfunction

   function automatic logic [DW-1:0] axis_prod(logic signed [23:0] p,
         logic signed [15:0] org, logic [14:0] ssz, logic [14:0] dsz);
      logic signed [XW-1:0] t, top;
      logic [TW-1:0] tc;
      t   = XW'(p) - (XW'(org) <<< 8);
      top = $signed({{(XW-15){1'b0}}, ssz}) <<< 8;
      tc  = (t < 0) ? '0 : ((t > top) ? top[TW-1:0] : t[TW-1:0]);
      return DW'(tc) * DW'(dsz);
   endfunction

   function automatic logic [14:0] axis_place(logic fnd, logic signed [23:0] p,
         logic [TW-1:0] q, logic signed [15:0] dorg, logic [14:0] dsz,
         logic signed [15:0] borg, logic [14:0] bsz);
      logic signed [XW-1:0] v, last, lx, w, r, mx;
      v    = (XW'(dorg) <<< 8) + $signed({{(XW-TW){1'b0}}, q});
      last = (XW'(dorg) + ((dsz != '0) ? $signed({{(XW-15){1'b0}}, dsz}) - XW'(1)
              : XW'(0))) <<< 8;
      lx   = fnd ? ((v < last) ? v : last) : XW'(p);
      w    = lx - (XW'(borg) <<< 8);
      r    = (w + XW'(128)) >>> 8;
      mx   = $signed({{(XW-15){1'b0}}, bsz}) - XW'(1);
      if (w < 0)       return '0;
      else if (r > mx) return mx[14:0];
      else             return r[14:0];
   endfunction

   function automatic void div_lane(logic [DW-1:0] num, logic [15:0] rem,
         logic [14:0] d, output logic [DW-1:0] num_o, output logic [15:0] rem_o);
      logic [15:0] r2;
      logic        ge;
      r2    = {rem[14:0], num[DW-1]};
      ge    = (r2 >= {1'b0, d});
      rem_o = ge ? (r2 - {1'b0, d}) : r2;
      num_o = {num[DW-2:0], ge};
   endfunction

   assign in_slot = req_tdata[1:0];
   assign in_src  = '{left: req_tdata[17:2], top: req_tdata[33:18],
                      width: req_tdata[48:34], height: req_tdata[63:49]};
   assign in_dst  = '{left: req_tdata[79:64], top: req_tdata[95:80],
                      width: req_tdata[110:96], height: req_tdata[125:111]};

   assign lim     = (32'(count_ff) > MAX_SCREENS) ? CW'(MAX_SCREENS) : CW'(count_ff);
   assign cur_src = src_tab_ff[idx_ff[IW-1:0]];
   assign sel_src = src_tab_ff[best_ff];
   assign sel_dst = dst_tab_ff[best_ff];
   assign dist_sum = DSW'(sqx_ff) + DSW'(sqy_ff);

   assign pos_x_in = axis_place(found_ff, px_ff, numx_ff[TW-1:0], sel_dst.left,
                                sel_dst.width, org_x_ff, box_w_ff);
   assign pos_y_in = axis_place(found_ff, py_ff, numy_ff[TW-1:0], sel_dst.top,
                                sel_dst.height, org_y_ff, box_h_ff);

   assign sts.more     = (idx_ff < lim);
   assign sts.div_done = (dcnt_ff == 6'(DW - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, pos_y_ff, pos_x_ff};

   always_ff @(posedge clock) begin
      logic [DW-1:0] nx, ny;
      logic [15:0]   rx, ry;
      if (reset) begin
         count_ff     <= '0;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         box_w_ff     <= '0;
         box_h_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         dcnt_ff      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SCREEN_COUNT: count_ff <= csr_data[2:0];
               CSR_BOX_ORIGIN_X: org_x_ff <= csr_data;
               CSR_BOX_ORIGIN_Y: org_y_ff <= csr_data;
               CSR_BOX_WIDTH:    box_w_ff <= csr_data[14:0];
               CSR_BOX_HEIGHT:   box_h_ff <= csr_data[14:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            if (req_action == ACT_LOAD) begin
               if (32'(in_slot) < MAX_SCREENS) begin
                  src_tab_ff[IW'(in_slot)] <= in_src;
                  dst_tab_ff[IW'(in_slot)] <= in_dst;
               end
            end else begin
               px_ff    <= req_tdata[149:126];
               py_ff    <= req_tdata[173:150];
               idx_ff   <= '0;
               best_ff  <= '0;
               found_ff <= 1'b0;
            end
         end
         if (cmd.fetch) begin
            dx_ff   <= axis_dx(px_ff, cur_src.left, cur_src.width);
            dy_ff   <= axis_dx(py_ff, cur_src.top, cur_src.height);
            skip_ff <= (cur_src.width == '0) || (cur_src.height == '0);
         end
         if (cmd.square) begin
            sqx_ff <= dx_ff * dx_ff;
            sqy_ff <= dy_ff * dy_ff;
         end
         if (cmd.compare) begin
            if (!skip_ff && (!found_ff || dist_sum < best_d_ff)) begin
               found_ff  <= 1'b1;
               best_d_ff <= dist_sum;
               best_ff   <= idx_ff[IW-1:0];
            end
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.map_set) begin
            numx_ff <= axis_prod(px_ff, sel_src.left, sel_src.width, sel_dst.width);
            numy_ff <= axis_prod(py_ff, sel_src.top, sel_src.height, sel_dst.height);
            remx_ff <= '0;
            remy_ff <= '0;
            dcnt_ff <= '0;
         end
         if (cmd.div_step) begin
            div_lane(numx_ff, remx_ff, sel_src.width, nx, rx);
            div_lane(numy_ff, remy_ff, sel_src.height, ny, ry);
            numx_ff <= nx;
            remx_ff <= rx;
            numy_ff <= ny;
            remy_ff <= ry;
            dcnt_ff <= dcnt_ff + 6'd1;
         end
         if (cmd.place && box_w_ff != '0 && box_h_ff != '0) begin
            rsp_valid_ff <= 1'b1;
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// File: hdl/nearest_screen_pointer_mapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_screen_pointer_mapper_unit
// Maps an absolute Q16.8 pointer onto the nearest screen of a layout and
// places it, rounded and clamped, inside the layout box.
// A load word is stored on acceptance. A motion word walks the searched screens
// (fetch, square and compare for each screen), runs the 38-step serial divider
// and then places the result once the result register is free.
// The result register frees the input while a result waits.
// Sync reset clears control, layout and valid flags; table undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_screen_pointer_mapper_unit #(
   parameter int MAX_SCREENS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // slot, src_left, src_top, src_width, src_height, dst_left, dst_top,
   // dst_width, dst_height, point_x, point_y
   input  logic [nspm_pkg::REQ_W-1:0] req_tdata,
   input  logic                       req_tuser,   // action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [nspm_pkg::RSP_W-1:0] rsp_tdata,   // pos_x, pos_y
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_data
);
   import nspm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   nspm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   nspm_dp #(.MAX_SCREENS(MAX_SCREENS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_action (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   a_busy_after_motion: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ACT_MAP |=> !req_tready)
      else $error("input taken during motion work");

   a_rsp_from_place: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.place))
      else $error("result raised without placement");

   a_place_free: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> sts.out_free)
      else $error("result register overwritten");

endmodule

// File: tb/nearest_screen_pointer_mapper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_screen_pointer_mapper_unit_tb
// Drives screen loads, motion words and register writes with random idling
// on both streams. A scoreboard predicts each position and checks the outputs.
// ----------------------------------------------------------------------------
module nearest_screen_pointer_mapper_unit_tb;
   import nspm_pkg::*;

   class position_board;
      rect_type    src_tab [4];
      rect_type    dst_tab [4];
      logic [2:0]  screen_count;
      int          org_x, org_y, box_w, box_h;
      logic [29:0] pending [$];
      int          errors;

      function new();
         screen_count = 0; org_x = 0; org_y = 0; box_w = 0; box_h = 0; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            CSR_SCREEN_COUNT: screen_count = val[2:0];
            CSR_BOX_ORIGIN_X: org_x = $signed(val);
            CSR_BOX_ORIGIN_Y: org_y = $signed(val);
            CSR_BOX_WIDTH:    box_w = val[14:0];
            CSR_BOX_HEIGHT:   box_h = val[14:0];
            default: ;
         endcase
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint scale_axis(longint p, longint s0, longint ssz, longint d0,
                                  longint dsz);
         longint t, v, lst;
         t = clip(p - s0 * 256, 0, ssz * 256);
         v = d0 * 256 + (t * dsz) / ssz;
         lst = (d0 + (dsz > 0 ? dsz - 1 : 0)) * 256;
         return v < lst ? v : lst;
      endfunction

      function longint round_place(longint q, longint org, longint sz);
         longint v, w;
         v = q - org * 256;
         w = v >= 0 ? (v + 128) / 256 : -((-v + 128) / 256);
         return clip(w, 0, sz - 1);
      endfunction

      function void note_word(logic act, logic [REQ_W-1:0] d);
         longint px, py, lx, ly, dx, dy, dd, best_d, sl, st, sw, sh;
         int n, best;
         bit found;
         rect_type s, o;
         if (act == ACT_LOAD) begin
            src_tab[d[1:0]] = '{left: d[17:2], top: d[33:18],
                                width: d[48:34], height: d[63:49]};
            dst_tab[d[1:0]] = '{left: d[79:64], top: d[95:80],
                                width: d[110:96], height: d[125:111]};
            return;
         end
         px = $signed(d[149:126]);
         py = $signed(d[173:150]);
         n = screen_count > 4 ? 4 : screen_count;
         found = 0; best = 0; best_d = 0;
         for (int i = 0; i < n; i++) begin
            s = src_tab[i];
            if (s.width == 0 || s.height == 0) continue;
            sl = longint'(s.left);
            st = longint'(s.top);
            sw = longint'(s.width);
            sh = longint'(s.height);
            dx = clip(px, sl * 256, (sl + sw - 1) * 256) - px;
            dy = clip(py, st * 256, (st + sh - 1) * 256) - py;
            dd = dx * dx + dy * dy;
            if (!found || dd < best_d) begin
               found = 1; best_d = dd; best = i;
            end
         end
         lx = px; ly = py;
         if (found) begin
            s = src_tab[best]; o = dst_tab[best];
            lx = scale_axis(px, s.left, s.width, o.left, o.width);
            ly = scale_axis(py, s.top, s.height, o.top, o.height);
         end
         if (box_w == 0 || box_h == 0) return;
         pending.push_back({15'(round_place(ly, org_y, box_h)),
                            15'(round_place(lx, org_x, box_w))});
      endfunction

      function void check_word(logic [RSP_W-1:0] d);
         logic [29:0] e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[14:0] !== e[14:0]) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, e[14:0], d[14:0]);
            errors++;
         end
         if (d[29:15] !== e[29:15]) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, e[29:15], d[29:15]);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   position_board board;
   bit calm;
   bit loaded [4];
   longint cycles;

   nearest_screen_pointer_mapper_unit uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);

   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   task automatic send_word(logic act, logic [REQ_W-1:0] d);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tvalid = 1; req_tuser = act; req_tdata = d;
      do @(posedge clock); while (!req_tready);
      board.note_word(act, d);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      csr_valid = 1; csr_index = idx; csr_data = val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [15:0] rnd_coord(bit wide);
      return wide ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
   endfunction

   function automatic logic [14:0] rnd_size(bit wide);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 15'h7fff;
         default: return wide ? 15'($urandom) : 15'($urandom_range(1, 300));
      endcase
   endfunction

   task automatic send_load(int s, bit wide);
      logic [REQ_W-1:0] d;
      d = '0;
      d[1:0] = 2'(s);
      d[63:2] = {rnd_size(wide), rnd_size(wide), rnd_coord(wide), rnd_coord(wide)};
      d[125:64] = {rnd_size(wide), rnd_size(wide), rnd_coord(wide), rnd_coord(wide)};
      d[173:126] = 48'($urandom);
      if ($urandom_range(0, 3) == 0) d[63:2] = {15'd1, 15'd1, 16'h8000, 16'h7fff};
      send_word(ACT_LOAD, d);
      loaded[s] = 1;
   endtask

   task automatic send_point(bit wide);
      logic [REQ_W-1:0] d;
      d = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d[REQ_W-1:174] = '0;
      if (!wide) begin
         d[149:126] = 24'($urandom_range(0, 160000) - 80000);
         d[173:150] = 24'($urandom_range(0, 160000) - 80000);
      end
      send_word(ACT_MAP, d);
   endtask

   task automatic set_count(int c);
      int lim;
      lim = c > 4 ? 4 : c;
      for (int i = 0; i < lim; i++) if (!loaded[i]) send_load(i, 0);
      drain();
      write_csr(CSR_SCREEN_COUNT, 16'(c));
   endtask

   initial begin
      logic [REQ_W-1:0] d;
      board = new();
      calm = 0;
      reset = 1; req_tvalid = 0; req_tuser = 0; req_tdata = '0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // empty box and no screens
      send_point(1);
      drain();
      write_csr(CSR_BOX_WIDTH, 16'd1);
      write_csr(CSR_BOX_HEIGHT, 16'h7fff);
      d = '0; d[149:126] = 24'h7fffff; d[173:150] = 24'h800000;
      send_word(ACT_MAP, d);
      d[149:126] = 24'h000080; d[173:150] = 24'hffff80;
      send_word(ACT_MAP, d);
      for (int i = 0; i < 4; i++) send_load(i, 1);
      drain();
      write_csr(CSR_SCREEN_COUNT, 16'd7);
      write_csr(CSR_BOX_ORIGIN_X, 16'h8000);
      write_csr(CSR_BOX_ORIGIN_Y, 16'h7fff);
      write_csr(CSR_BOX_WIDTH, 16'h7fff);
      for (int i = 0; i < 8; i++) send_point(i[0]);

      for (int ph = 0; ph < 20; ph++) begin
         drain();
         if (ph == 19) calm = 1;
         set_count($urandom_range(0, 7));
         write_csr(CSR_BOX_ORIGIN_X, ph % 5 == 0 ? 16'h8000 : rnd_coord(ph % 3 == 0));
         write_csr(CSR_BOX_ORIGIN_Y, ph % 5 == 1 ? 16'h7fff : rnd_coord(ph % 3 == 0));
         write_csr(CSR_BOX_WIDTH, ph == 7 ? 16'd0 : 16'(rnd_size(ph % 2 != 0)));
         write_csr(CSR_BOX_HEIGHT, ph == 7 ? 16'h7fff : 16'(rnd_size(ph % 3 != 0)));
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_load(int'($urandom_range(0, 3)), $urandom_range(0, 1) != 0);
            else send_point($urandom_range(0, 3) == 0);
         end
      end
      drain();
      if (board.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
